[src/modified_fm_oscillator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the modified FM oscillator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODIFIED_FM_OSCILLATOR_ASSERT_SVH
`define MODIFIED_FM_OSCILLATOR_ASSERT_SVH

// same-cycle implication
`define MFO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfo assertion failed");

// next-cycle implication
`define MFO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfo assertion failed");

`endif

[src/mfo_pkg.sv]
// ----------------------------------------------------------------------------
// mfo_pkg
// Types, constants and the sine table of the modified FM oscillator.
// ----------------------------------------------------------------------------
package mfo_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int TAB_AW           = 8;
  localparam logic [TAB_AW-1:0] TAB_QUARTER = TAB_AW'(SINE_TABLE_DEPTH / 4);
  localparam logic [31:0] BASE_STEP_RESET = 32'd39370534;
  localparam logic signed [32:0] INV_TWO_PI_Q32 = 33'sd683565276;

  typedef logic signed [31:0] sine_tab_t [SINE_TABLE_DEPTH];

  typedef enum logic [3:0] {
    OP_CN      = 4'd0,
    OP_PC_LO   = 4'd1,
    OP_PC_HI   = 4'd2,
    OP_U_LO    = 4'd3,
    OP_U_HI    = 4'd4,
    OP_PM_LO   = 4'd5,
    OP_PM_HI   = 4'd6,
    OP_SK      = 4'd7,
    OP_SK_SIN  = 4'd8,
    OP_RAD_C   = 4'd9,
    OP_RK      = 4'd10,
    OP_RK_COS  = 4'd11,
    OP_RAD_T   = 4'd12,
    OP_GAIN    = 4'd13,
    OP_REAL    = 4'd14,
    OP_IMAG    = 4'd15
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
    logic mul_en;
    logic wb_en;
    logic out_load;
  } cmd_t;

  // sin(pi/2 * x), x in Q30
  function automatic logic [63:0] quarter_sine(logic [63:0] x);
    logic [63:0] coef [7];
    logic [63:0] x2;
    logic [63:0] p;
    coef[0] = 64'd1686629713; coef[1] = 64'd693598669; coef[2] = 64'd85569305;
    coef[3] = 64'd5026995;    coef[4] = 64'd172272;    coef[5] = 64'd3864;
    coef[6] = 64'd61;
    x2 = (x * x) >> 30;
    p  = coef[6];
    for (int j = 5; j >= 0; j--) begin
      p = coef[j] - ((p * x2) >> 30);
    end
    p = (p * x) >> 30;
    if (p > (64'd1 << 30)) p = 64'd1 << 30;
    return p;
  endfunction

  function automatic sine_tab_t build_tab();
    sine_tab_t   t;
    logic [63:0] u, q, rem, v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      u   = 64'(4 * i);
      q   = u / SINE_TABLE_DEPTH;
      rem = u % SINE_TABLE_DEPTH;
      if (q[0]) rem = 64'(SINE_TABLE_DEPTH) - rem;
      v = quarter_sine((rem << 30) / SINE_TABLE_DEPTH);
      if (q >= 64'd2) v = -v;
      t[i] = v[31:0];
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

endpackage

[src/mfo_ctrl.sv]
// ----------------------------------------------------------------------------
// mfo_ctrl
// Sequencer: steps the datapath through sixteen multiply/writeback pairs.
// ----------------------------------------------------------------------------
`include "modified_fm_oscillator_assert.svh"

module mfo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output mfo_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_WB   = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  mfo_pkg::op_t  op_r, op_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_busy;

  assign out_busy  = out_valid_r && !out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.load      = 1'b0;
    cmd.op        = op_r;
    cmd.mul_en    = 1'b0;
    cmd.wb_en     = 1'b0;
    cmd.out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        op_nxt = mfo_pkg::OP_CN;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_WB;
      end
      ST_WB: begin
        if (op_r == mfo_pkg::OP_IMAG) begin
          // hold the last writeback until the output register frees up
          if (!out_busy) begin
            cmd.wb_en     = 1'b1;
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
            op_nxt        = mfo_pkg::OP_CN;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.wb_en = 1'b1;
          op_nxt    = mfo_pkg::op_t'(op_r + 4'd1);
          state_nxt = ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= mfo_pkg::OP_CN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MFO_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == ST_MUL && op_r == mfo_pkg::OP_CN)
  `MFO_ASSERT_NEXT(a_stall_holds, state_r == ST_WB && op_r == mfo_pkg::OP_IMAG && out_busy, state_r == ST_WB && out_valid_r)
  `MFO_ASSERT_NEXT(a_finish_valid, cmd.out_load, out_valid_r && state_r == ST_IDLE)
  `MFO_ASSERT_NOW(a_idle_op, state_r == ST_IDLE, op_r == mfo_pkg::OP_CN)

endmodule

[src/mfo_datapath.sv]
// ----------------------------------------------------------------------------
// mfo_datapath
// Shared 33x33 signed multiplier, phase accumulators, sine table, output regs.
// ----------------------------------------------------------------------------
module mfo_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  mfo_pkg::cmd_t      cmd,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [15:0] in_amplitude,
  input  logic [15:0]        in_carrier_ratio,
  input  logic [15:0]        in_mod_ratio,
  input  logic signed [15:0] in_phase_depth,
  input  logic signed [15:0] in_carrier_depth,
  input  logic signed [15:0] in_mod_index,
  input  logic               in_block_end,
  output logic signed [15:0] out_real,
  output logic signed [15:0] out_imag,
  output logic               out_block_end_out
);

  logic [31:0]        base_step_r, sample_index_r, n_r;
  logic signed [15:0] a_r, r_r, s_r, k_r;
  logic [15:0]        c_r, m_r;
  logic               be_r;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic [47:0]        t_r, u_r, acc_r;
  logic [31:0]        pc_r;
  logic signed [31:0] f_r, rad_r, g_r;
  logic signed [31:0] sin_m_r, cos_m_r, cos_c_r, trig_c_r, trig_s_r;
  logic signed [15:0] real_r;
  logic signed [15:0] real_q_r, imag_q_r;
  logic               be_q_r;

  logic [39:0]        pc_sum;
  logic [47:0]        hi_sum;
  logic [31:0]        carrier;
  logic [mfo_pkg::TAB_AW-1:0] pm_idx, car_idx, th_idx;
  logic signed [65:0] rnd;
  logic signed [65:0] shv;
  logic signed [15:0] sat;

  localparam logic signed [65:0] SAT_HI = 66'sd32767;
  localparam logic signed [65:0] SAT_LO = -66'sd32768;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      mfo_pkg::OP_CN:     begin mul_a = {17'd0, c_r};        mul_b = {1'b0, n_r};          end
      mfo_pkg::OP_PC_LO:  begin mul_a = {1'b0, base_step_r}; mul_b = {1'b0, t_r[31:0]};    end
      mfo_pkg::OP_PC_HI:  begin mul_a = {1'b0, base_step_r}; mul_b = {17'd0, t_r[47:32]};  end
      mfo_pkg::OP_U_LO:   begin mul_a = {17'd0, m_r};        mul_b = {1'b0, t_r[31:0]};    end
      mfo_pkg::OP_U_HI:   begin mul_a = {17'd0, m_r};        mul_b = {17'd0, t_r[47:32]};  end
      mfo_pkg::OP_PM_LO:  begin mul_a = {1'b0, base_step_r}; mul_b = {1'b0, u_r[31:0]};    end
      mfo_pkg::OP_PM_HI:  begin mul_a = {1'b0, base_step_r}; mul_b = {17'd0, u_r[47:32]};  end
      mfo_pkg::OP_SK:     begin mul_a = 33'(s_r);            mul_b = 33'(k_r);             end
      mfo_pkg::OP_SK_SIN: begin mul_a = 33'(f_r);            mul_b = 33'(sin_m_r);         end
      mfo_pkg::OP_RAD_C:  begin mul_a = 33'(rad_r);          mul_b = mfo_pkg::INV_TWO_PI_Q32; end
      mfo_pkg::OP_RK:     begin mul_a = 33'(r_r);            mul_b = 33'(k_r);             end
      mfo_pkg::OP_RK_COS: begin mul_a = 33'(f_r);            mul_b = 33'(cos_m_r);         end
      mfo_pkg::OP_RAD_T:  begin mul_a = 33'(rad_r);          mul_b = mfo_pkg::INV_TWO_PI_Q32; end
      mfo_pkg::OP_GAIN:   begin mul_a = 33'(a_r);            mul_b = 33'(cos_c_r);         end
      mfo_pkg::OP_REAL:   begin mul_a = 33'(g_r);            mul_b = 33'(trig_c_r);        end
      mfo_pkg::OP_IMAG:   begin mul_a = 33'(g_r);            mul_b = 33'(trig_s_r);        end
      default:            begin mul_a = '0;                  mul_b = '0;                   end
    endcase
  end

  // phase-word assembly from split partial products
  assign pc_sum  = acc_r[39:0] + {prod_r[7:0], 32'd0};
  assign hi_sum  = acc_r + {prod_r[15:0], 32'd0};
  assign pm_idx  = hi_sum[47:40];
  assign carrier = pc_r - prod_r[55:24];
  assign car_idx = carrier[31:24] + mfo_pkg::TAB_QUARTER;
  assign th_idx  = prod_r[55:48];

  // round half up, then clamp to 16 bits
  assign rnd = prod_r + (66'sd1 <<< 44);
  assign shv = rnd >>> 45;
  always_comb begin
    if (shv > SAT_HI)      sat = 16'sh7fff;
    else if (shv < SAT_LO) sat = -16'sh8000;
    else                   sat = shv[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_step_r    <= mfo_pkg::BASE_STEP_RESET;
      sample_index_r <= '0;
    end else begin
      if (cfg_we) base_step_r <= cfg_wdata;
      if (cmd.load) sample_index_r <= sample_index_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= sample_index_r + 32'd1;
      a_r  <= in_amplitude;
      c_r  <= in_carrier_ratio;
      m_r  <= in_mod_ratio;
      r_r  <= in_phase_depth;
      s_r  <= in_carrier_depth;
      k_r  <= in_mod_index;
      be_r <= in_block_end;
    end
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    if (cmd.wb_en) begin
      case (cmd.op)
        mfo_pkg::OP_CN:     t_r <= prod_r[47:0];
        mfo_pkg::OP_PC_LO:  acc_r <= prod_r[47:0];
        mfo_pkg::OP_PC_HI:  pc_r <= pc_sum[39:8];
        mfo_pkg::OP_U_LO:   acc_r <= prod_r[47:0];
        mfo_pkg::OP_U_HI:   u_r <= hi_sum;
        mfo_pkg::OP_PM_LO:  acc_r <= prod_r[47:0];
        mfo_pkg::OP_PM_HI: begin
          sin_m_r <= mfo_pkg::SINE_TAB[pm_idx];
          cos_m_r <= mfo_pkg::SINE_TAB[pm_idx + mfo_pkg::TAB_QUARTER];
        end
        mfo_pkg::OP_SK:     f_r <= prod_r[31:0];
        mfo_pkg::OP_SK_SIN: rad_r <= prod_r[61:30];
        mfo_pkg::OP_RAD_C:  cos_c_r <= mfo_pkg::SINE_TAB[car_idx];
        mfo_pkg::OP_RK:     f_r <= prod_r[31:0];
        mfo_pkg::OP_RK_COS: rad_r <= prod_r[61:30];
        mfo_pkg::OP_RAD_T: begin
          trig_c_r <= mfo_pkg::SINE_TAB[th_idx + mfo_pkg::TAB_QUARTER];
          trig_s_r <= mfo_pkg::SINE_TAB[th_idx];
        end
        mfo_pkg::OP_GAIN:   g_r <= prod_r[46:15];
        mfo_pkg::OP_REAL:   real_r <= sat;
        mfo_pkg::OP_IMAG:   imag_q_r <= sat;
        default:            t_r <= t_r;
      endcase
    end
    if (cmd.out_load) begin
      real_q_r <= real_r;
      be_q_r   <= be_r;
    end
  end

  assign out_real          = real_q_r;
  assign out_imag          = imag_q_r;
  assign out_block_end_out = be_q_r;

endmodule

[src/modified_fm_oscillator.sv]
// Modified FM oscillator: one complex sample per accepted transaction.
// Each sample is computed by 16 multiply/writeback pairs on one shared 33x33
// multiplier; inputs are accepted only while idle, so a new sample is not taken
// until the previous one has had its last writeback.
// A new input is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous): sample index to zero, base_step to 39370534.
// ----------------------------------------------------------------------------
// modified_fm_oscillator
// Top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
module modified_fm_oscillator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_amplitude,
  input  logic [15:0]        in_carrier_ratio,
  input  logic [15:0]        in_mod_ratio,
  input  logic signed [15:0] in_phase_depth,
  input  logic signed [15:0] in_carrier_depth,
  input  logic signed [15:0] in_mod_index,
  input  logic               in_block_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_real,
  output logic signed [15:0] out_imag,
  output logic               out_block_end_out
);

  mfo_pkg::cmd_t cmd;

  mfo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mfo_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_amplitude      (in_amplitude),
    .in_carrier_ratio  (in_carrier_ratio),
    .in_mod_ratio      (in_mod_ratio),
    .in_phase_depth    (in_phase_depth),
    .in_carrier_depth  (in_carrier_depth),
    .in_mod_index      (in_mod_index),
    .in_block_end      (in_block_end),
    .out_real          (out_real),
    .out_imag          (out_imag),
    .out_block_end_out (out_block_end_out)
  );

endmodule
